// ----- rtl/qtt_pkg.sv -----
// types and constants shared by the query text tokenizer
`default_nettype none

package qtt_pkg;

  localparam int MaxResults = 3;
  localparam int FifoDepth  = 8;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChBang    = 8'h21;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChMinus   = 8'h2d;
  localparam logic [7:0] ChDot     = 8'h2e;
  localparam logic [7:0] ChLess    = 8'h3c;
  localparam logic [7:0] ChEq      = 8'h3d;
  localparam logic [7:0] ChGreater = 8'h3e;
  localparam logic [7:0] ChUnder   = 8'h5f;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_STRING,
    MODE_NUMBER,
    MODE_WORD,
    MODE_MINUS,
    MODE_CMP
  } mode_t;

  typedef enum logic [2:0] {
    KIND_STRING = 3'd0,
    KIND_NUMBER = 3'd1,
    KIND_WORD   = 3'd2,
    KIND_PUNCT  = 3'd3,
    KIND_END    = 3'd4,
    KIND_ERROR  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  text;
    logic        first;
    logic        last;
    logic        empty;
    logic        whole;
    logic        run_end;
  } result_t;

  typedef struct packed {
    logic [1:0]                   count;
    result_t [MaxResults-1:0]     slot;
  } push_t;

endpackage

`default_nettype wire

// ----- rtl/qtt_scan.sv -----
// input register and scanner: turns one source byte into up to three result items
`default_nettype none

module qtt_scan
  import qtt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] source_byte,
  input  wire logic       final_byte,
  input  wire logic       room,
  output push_t           push
);

  logic       item_valid;
  logic [7:0] item_byte;
  logic       item_final;
  logic       consume;

  mode_t      mode;
  logic [7:0] held_byte;
  logic       held_valid;
  logic       held_is_first;
  logic       saw_point;

  mode_t      mode_mid;
  logic [7:0] held_byte_mid;
  logic       held_valid_mid;
  logic       held_is_first_mid;
  logic       saw_point_mid;
  logic       restart;

  mode_t      mode_next;
  logic [7:0] held_byte_next;
  logic       held_valid_next;
  logic       held_is_first_next;
  logic       saw_point_next;

  result_t [MaxResults-1:0] res;
  logic [1:0]               res_count;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_cmp(input logic [7:0] c);
    return c inside {ChLess, ChGreater, ChBang, ChEq};
  endfunction

  function automatic logic is_lone_punct(input logic [7:0] c);
    return !is_space(c) && (c != ChHash) && (c != ChQuote) && !is_digit(c) &&
           (c != ChMinus) && !is_alpha(c) && (c != ChUnder) && !is_cmp(c);
  endfunction

  function automatic result_t make_res(input kind_t kind, input logic [7:0] text,
                                       input logic first, input logic last,
                                       input logic empty, input logic whole);
    result_t r;
    r.kind    = kind;
    r.text    = text;
    r.first   = first;
    r.last    = last;
    r.empty   = empty;
    r.whole   = whole;
    r.run_end = 1'b0;
    return r;
  endfunction

  // input register
  assign consume  = item_valid && room;
  assign in_stall = item_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_byte  <= source_byte;
      item_final <= final_byte;
    end
  end

  // next state
  always_comb begin
    mode_mid          = mode;
    held_byte_mid     = held_byte;
    held_valid_mid    = held_valid;
    held_is_first_mid = held_is_first;
    saw_point_mid     = saw_point;
    restart           = 1'b0;
    unique case (mode)
      MODE_COMMENT: begin
        if (item_byte == ChNewline) mode_mid = MODE_IDLE;
      end
      MODE_STRING: begin
        if (item_byte == ChQuote) begin
          mode_mid          = MODE_IDLE;
          held_byte_mid     = 8'd0;
          held_valid_mid    = 1'b0;
          held_is_first_mid = 1'b0;
          saw_point_mid     = 1'b0;
        end else begin
          held_is_first_mid = !held_valid;
          held_byte_mid     = item_byte;
          held_valid_mid    = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(item_byte) || (item_byte == ChDot && !saw_point)) begin
          if (item_byte == ChDot) saw_point_mid = 1'b1;
          held_is_first_mid = !held_valid;
          held_byte_mid     = item_byte;
          held_valid_mid    = 1'b1;
        end else begin
          restart = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_alpha(item_byte) || is_digit(item_byte) || item_byte == ChUnder) begin
          held_is_first_mid = !held_valid;
          held_byte_mid     = item_byte;
          held_valid_mid    = 1'b1;
        end else begin
          restart = 1'b1;
        end
      end
      MODE_MINUS: begin
        if (is_digit(item_byte)) begin
          mode_mid          = MODE_NUMBER;
          saw_point_mid     = 1'b0;
          held_is_first_mid = !held_valid;
          held_byte_mid     = item_byte;
          held_valid_mid    = 1'b1;
        end else begin
          restart = 1'b1;
        end
      end
      MODE_CMP: begin
        if (item_byte == ChEq) begin
          mode_mid          = MODE_IDLE;
          held_byte_mid     = 8'd0;
          held_valid_mid    = 1'b0;
          held_is_first_mid = 1'b0;
          saw_point_mid     = 1'b0;
        end else begin
          restart = 1'b1;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    if (restart) begin
      mode_mid          = MODE_IDLE;
      held_byte_mid     = 8'd0;
      held_valid_mid    = 1'b0;
      held_is_first_mid = 1'b0;
      saw_point_mid     = 1'b0;
      if (!is_space(item_byte)) begin
        if (item_byte == ChHash) begin
          mode_mid = MODE_COMMENT;
        end else if (item_byte == ChQuote) begin
          mode_mid = MODE_STRING;
        end else if (!is_lone_punct(item_byte)) begin
          held_byte_mid     = item_byte;
          held_valid_mid    = 1'b1;
          held_is_first_mid = 1'b1;
          if (is_digit(item_byte)) begin
            mode_mid = MODE_NUMBER;
          end else if (item_byte == ChMinus) begin
            mode_mid = MODE_MINUS;
          end else if (is_cmp(item_byte)) begin
            mode_mid = MODE_CMP;
          end else begin
            mode_mid = MODE_WORD;
          end
        end
      end
    end
  end

  always_comb begin
    if (item_final) begin
      mode_next          = MODE_IDLE;
      held_byte_next     = 8'd0;
      held_valid_next    = 1'b0;
      held_is_first_next = 1'b0;
      saw_point_next     = 1'b0;
    end else begin
      mode_next          = mode_mid;
      held_byte_next     = held_byte_mid;
      held_valid_next    = held_valid_mid;
      held_is_first_next = held_is_first_mid;
      saw_point_next     = saw_point_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      held_byte     <= 8'd0;
      held_valid    <= 1'b0;
      held_is_first <= 1'b0;
      saw_point     <= 1'b0;
    end else if (consume) begin
      mode          <= mode_next;
      held_byte     <= held_byte_next;
      held_valid    <= held_valid_next;
      held_is_first <= held_is_first_next;
      saw_point     <= saw_point_next;
    end
  end

  // result items
  always_comb begin
    res       = '0;
    res_count = 2'd0;
    unique case (mode)
      MODE_COMMENT: begin
      end
      MODE_STRING: begin
        if (item_byte == ChQuote) begin
          if (held_valid) begin
            res[res_count] = make_res(KIND_STRING, held_byte, held_is_first,
                                      1'b1, 1'b0, 1'b0);
          end else begin
            res[res_count] = make_res(KIND_STRING, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0);
          end
          res_count = res_count + 2'd1;
        end else if (held_valid) begin
          res[res_count] = make_res(KIND_STRING, held_byte, held_is_first,
                                    1'b0, 1'b0, 1'b0);
          res_count = res_count + 2'd1;
        end
      end
      MODE_NUMBER: begin
        if (!restart) begin
          if (held_valid) begin
            res[res_count] = make_res(KIND_NUMBER, held_byte, held_is_first,
                                      1'b0, 1'b0, 1'b0);
            res_count = res_count + 2'd1;
          end
        end else begin
          res[res_count] = make_res(KIND_NUMBER, held_byte, held_is_first,
                                    1'b1, 1'b0, !saw_point);
          res_count = res_count + 2'd1;
        end
      end
      MODE_WORD: begin
        if (!restart) begin
          if (held_valid) begin
            res[res_count] = make_res(KIND_WORD, held_byte, held_is_first,
                                      1'b0, 1'b0, 1'b0);
            res_count = res_count + 2'd1;
          end
        end else begin
          res[res_count] = make_res(KIND_WORD, held_byte, held_is_first,
                                    1'b1, 1'b0, 1'b0);
          res_count = res_count + 2'd1;
        end
      end
      MODE_MINUS: begin
        if (!restart) begin
          if (held_valid) begin
            res[res_count] = make_res(KIND_NUMBER, held_byte, held_is_first,
                                      1'b0, 1'b0, 1'b0);
            res_count = res_count + 2'd1;
          end
        end else begin
          res[res_count] = make_res(KIND_PUNCT, held_byte, 1'b1, 1'b1, 1'b0, 1'b0);
          res_count = res_count + 2'd1;
        end
      end
      MODE_CMP: begin
        if (!restart) begin
          res[res_count] = make_res(KIND_PUNCT, held_byte, 1'b1, 1'b0, 1'b0, 1'b0);
          res_count = res_count + 2'd1;
          res[res_count] = make_res(KIND_PUNCT, item_byte, 1'b0, 1'b1, 1'b0, 1'b0);
          res_count = res_count + 2'd1;
        end else begin
          res[res_count] = make_res(KIND_PUNCT, held_byte, 1'b1, 1'b1, 1'b0, 1'b0);
          res_count = res_count + 2'd1;
        end
      end
      default: begin
      end
    endcase

    if (restart && is_lone_punct(item_byte)) begin
      res[res_count] = make_res(KIND_PUNCT, item_byte, 1'b1, 1'b1, 1'b0, 1'b0);
      res_count = res_count + 2'd1;
    end

    if (item_final) begin
      if (mode_mid == MODE_STRING) begin
        res[res_count] = make_res(KIND_ERROR, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0);
        res_count = res_count + 2'd1;
      end else begin
        if (held_valid_mid) begin
          if (mode_mid == MODE_NUMBER) begin
            res[res_count] = make_res(KIND_NUMBER, held_byte_mid, held_is_first_mid,
                                      1'b1, 1'b0, !saw_point_mid);
            res_count = res_count + 2'd1;
          end else if (mode_mid == MODE_WORD) begin
            res[res_count] = make_res(KIND_WORD, held_byte_mid, held_is_first_mid,
                                      1'b1, 1'b0, 1'b0);
            res_count = res_count + 2'd1;
          end else if (mode_mid == MODE_MINUS || mode_mid == MODE_CMP) begin
            res[res_count] = make_res(KIND_PUNCT, held_byte_mid, 1'b1, 1'b1,
                                      1'b0, 1'b0);
            res_count = res_count + 2'd1;
          end
        end
        res[res_count] = make_res(KIND_END, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0);
        res_count = res_count + 2'd1;
      end
    end

    if (res_count != 2'd0) begin
      res[res_count - 2'd1].run_end = 1'b1;
    end
  end

  assign push.count = consume ? res_count : 2'd0;
  assign push.slot  = res;

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (consume && item_final) |=> (mode == MODE_IDLE && !held_valid))
    else $error("scanner not idle after final item");

  a_run_end_marks_last: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |->
      ((push.count == 2'd1 && push.slot[0].run_end) ||
       (push.count == 2'd2 && push.slot[1].run_end && !push.slot[0].run_end) ||
       (push.count == 2'd3 && push.slot[2].run_end && !push.slot[1].run_end &&
        !push.slot[0].run_end)))
    else $error("run end not on last result of item");

  a_no_push_when_stalled: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (push.count == 2'd0))
    else $error("results pushed while input stalled");

endmodule

`default_nettype wire

// ----- rtl/qtt_fifo.sv -----
// result queue: takes up to three items a cycle, hands out one a cycle while out_stall is low
`default_nettype none

module qtt_fifo
  import qtt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire push_t   push,
  output logic         room,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      head
);

  result_t [FifoDepth-1:0] entries;
  logic [FifoPtrW-1:0]     wr_ptr;
  logic [FifoPtrW-1:0]     rd_ptr;
  logic [FifoCntW-1:0]     count;
  logic [FifoCntW-1:0]     count_next;
  logic                    pop;

  assign out_valid  = (count != '0);
  assign pop        = out_valid && !out_stall;
  assign room       = (count <= FifoCntW'(FifoDepth - MaxResults));
  assign head       = entries[rd_ptr];
  assign count_next = count + FifoCntW'(push.count) - FifoCntW'(pop);

  always_ff @(posedge clk) begin
    if (push.count > 2'd0) entries[wr_ptr] <= push.slot[0];
    if (push.count > 2'd1) entries[wr_ptr + FifoPtrW'(1)] <= push.slot[1];
    if (push.count > 2'd2) entries[wr_ptr + FifoPtrW'(2)] <= push.slot[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FifoPtrW'(push.count);
      if (pop) rd_ptr <= rd_ptr + FifoPtrW'(1);
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FifoCntW'(FifoDepth))
    else $error("result queue overfilled");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (count <= FifoCntW'(FifoDepth - MaxResults)))
    else $error("items pushed without room");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (count == '0 && wr_ptr == rd_ptr))
    else $error("result queue not empty after reset");

endmodule

`default_nettype wire

// ----- rtl/query_text_tokenizer.sv -----
// query text tokenizer top level
//
// input channel: one source byte per item (source_byte, final_byte), handshake
// in_valid / in_stall. output channel: one token byte per item (token_kind,
// text_byte, token_first, token_last, token_empty, whole_number, run_end),
// handshake out_valid / out_stall.
// an accepted byte is scanned straight out of the input register, and its
// results land in an eight-entry result queue once the queue has room; the
// first result is offered at the queue head once it is in the queue.
// a byte gives zero to three results; the queue hands out one per cycle while
// out_stall is low, so the block takes one byte per cycle while bytes average
// one result or less. in_stall rises while the input register is full and the
// queue has fewer than three free entries.
// final_byte flushes the held byte and adds an end item (or an error item
// for an open string), then the scanner is idle again.
// reset empties the queue and the input register and returns the scanner to
// idle; a stalled output item stays put until out_stall drops.
`default_nettype none

module query_text_tokenizer
  import qtt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] source_byte,
  input  wire logic       final_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      token_kind,
  output logic [7:0]      text_byte,
  output logic            token_first,
  output logic            token_last,
  output logic            token_empty,
  output logic            whole_number,
  output logic            run_end
);

  push_t   push;
  logic    room;
  result_t head;

  qtt_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .source_byte (source_byte),
    .final_byte  (final_byte),
    .room        (room),
    .push        (push)
  );

  qtt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign token_kind   = head.kind;
  assign text_byte    = head.text;
  assign token_first  = head.first;
  assign token_last   = head.last;
  assign token_empty  = head.empty;
  assign whole_number = head.whole;
  assign run_end      = head.run_end;

endmodule

`default_nettype wire

// ----- verif/query_text_tokenizer_test.sv -----
// self-checking testbench for the query text tokenizer: directed table plus random sources
`timescale 1ns / 1ps

module query_text_tokenizer_test
  import qtt_pkg::*;
();

  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7a;

  typedef struct packed {
    logic [7:0]           src;
    logic                 fin;
    logic                 typed;
    logic [1:0]           n;
    result_t [2:0]        want;
  } table_row_t;

  typedef struct packed {
    logic [7:0] src;
    logic       fin;
  } source_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] source_byte = 8'h00;
  logic       final_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] token_kind;
  logic [7:0] text_byte;
  logic       token_first;
  logic       token_last;
  logic       token_empty;
  logic       whole_number;
  logic       run_end;

  query_text_tokenizer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .source_byte  (source_byte),
    .final_byte   (final_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .text_byte    (text_byte),
    .token_first  (token_first),
    .token_last   (token_last),
    .token_empty  (token_empty),
    .whole_number (whole_number),
    .run_end      (run_end)
  );

  always #5 clk = ~clk;

  // scanner copy
  mode_t      scan;
  logic [7:0] held;
  logic       held_v;
  logic       held_first;
  logic       point;
  result_t    step_out[$];

  result_t      token_queue[$];
  table_row_t   directed[$];
  source_item_t sources[$];

  int errors = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;

  result_t got;
  result_t want;

  function automatic result_t tok(kind_t k, logic [7:0] t, logic f, logic l, logic e,
                                  logic w, logic r);
    result_t x;
    x.kind    = k;
    x.text    = t;
    x.first   = f;
    x.last    = l;
    x.empty   = e;
    x.whole   = w;
    x.run_end = r;
    return x;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic logic starts_word(logic [7:0] c);
    return (c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ) || c == ChUnder;
  endfunction

  function void emit(kind_t k, logic [7:0] t, logic f, logic l, logic e, logic w);
    step_out = {step_out, tok(k, t, f, l, e, w, 1'b0)};
  endfunction

  function void go_idle();
    scan       = MODE_IDLE;
    held_v     = 1'b0;
    held_first = 1'b0;
    held       = 8'h00;
    point      = 1'b0;
  endfunction

  function void hold_first_byte(logic [7:0] c, mode_t m);
    held       = c;
    held_v     = 1'b1;
    held_first = 1'b1;
    scan       = m;
  endfunction

  function void shift_in(kind_t k, logic [7:0] c);
    if (held_v) begin
      emit(k, held, held_first, 1'b0, 1'b0, 1'b0);
      held_first = 1'b0;
    end else begin
      held_first = 1'b1;
    end
    held   = c;
    held_v = 1'b1;
  endfunction

  function void start_token(logic [7:0] c);
    go_idle();
    if (is_space(c)) begin
      return;
    end
    if (c == ChHash) begin
      scan = MODE_COMMENT;
    end else if (c == ChQuote) begin
      scan = MODE_STRING;
    end else if (is_digit(c)) begin
      hold_first_byte(c, MODE_NUMBER);
    end else if (c == ChMinus) begin
      hold_first_byte(c, MODE_MINUS);
    end else if (starts_word(c)) begin
      hold_first_byte(c, MODE_WORD);
    end else if (c == ChLess || c == ChGreater || c == ChBang || c == ChEq) begin
      hold_first_byte(c, MODE_CMP);
    end else begin
      emit(KIND_PUNCT, c, 1'b1, 1'b1, 1'b0, 1'b0);
    end
  endfunction

  function void scan_byte(logic [7:0] c, logic fin);
    result_t tail;
    step_out.delete();
    case (scan)
      MODE_COMMENT: begin
        if (c == ChNewline) go_idle();
      end
      MODE_STRING: begin
        if (c == ChQuote) begin
          if (held_v) emit(KIND_STRING, held, held_first, 1'b1, 1'b0, 1'b0);
          else emit(KIND_STRING, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0);
          go_idle();
        end else begin
          shift_in(KIND_STRING, c);
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c) || (c == ChDot && !point)) begin
          if (c == ChDot) point = 1'b1;
          shift_in(KIND_NUMBER, c);
        end else begin
          emit(KIND_NUMBER, held, held_first, 1'b1, 1'b0, !point);
          start_token(c);
        end
      end
      MODE_WORD: begin
        if (starts_word(c) || is_digit(c)) begin
          shift_in(KIND_WORD, c);
        end else begin
          emit(KIND_WORD, held, held_first, 1'b1, 1'b0, 1'b0);
          start_token(c);
        end
      end
      MODE_MINUS: begin
        if (is_digit(c)) begin
          scan  = MODE_NUMBER;
          point = 1'b0;
          shift_in(KIND_NUMBER, c);
        end else begin
          emit(KIND_PUNCT, held, 1'b1, 1'b1, 1'b0, 1'b0);
          start_token(c);
        end
      end
      MODE_CMP: begin
        if (c == ChEq) begin
          emit(KIND_PUNCT, held, 1'b1, 1'b0, 1'b0, 1'b0);
          emit(KIND_PUNCT, c, 1'b0, 1'b1, 1'b0, 1'b0);
          go_idle();
        end else begin
          emit(KIND_PUNCT, held, 1'b1, 1'b1, 1'b0, 1'b0);
          start_token(c);
        end
      end
      default: start_token(c);
    endcase
    if (fin) begin
      if (scan == MODE_STRING) begin
        emit(KIND_ERROR, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0);
      end else begin
        if (held_v) begin
          case (scan)
            MODE_NUMBER: emit(KIND_NUMBER, held, held_first, 1'b1, 1'b0, !point);
            MODE_WORD:   emit(KIND_WORD, held, held_first, 1'b1, 1'b0, 1'b0);
            MODE_MINUS,
            MODE_CMP:    emit(KIND_PUNCT, held, 1'b1, 1'b1, 1'b0, 1'b0);
            default: ;
          endcase
        end
        emit(KIND_END, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0);
      end
      go_idle();
    end
    if (step_out.size() > 0) begin
      tail = step_out[step_out.size() - 1];
      tail.run_end = 1'b1;
      step_out[step_out.size() - 1] = tail;
    end
  endfunction

  task automatic note_mismatch(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task automatic row(logic [7:0] b, logic fin);
    table_row_t r;
    r       = '0;
    r.src   = b;
    r.fin   = fin;
    directed = {directed, r};
  endtask

  task automatic row_typed(logic [7:0] b, logic fin, logic [1:0] n, result_t w0 = '0,
                           result_t w1 = '0, result_t w2 = '0);
    table_row_t r;
    r         = '0;
    r.src     = b;
    r.fin     = fin;
    r.typed   = 1'b1;
    r.n       = n;
    r.want[0] = w0;
    r.want[1] = w1;
    r.want[2] = w2;
    directed = {directed, r};
  endtask

  task automatic send(logic [7:0] b, logic fin);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    source_byte <= b;
    final_byte  <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic put_byte(logic [7:0] b);
    source_item_t s;
    s.src = b;
    s.fin = 1'b0;
    sources = {sources, s};
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(52);
    if (r == 52) return ChUnder;
    if (r < 26) return ChLowA + 8'(r);
    return ChUpA + 8'(r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return ChZero + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_space();
    int r;
    r = $urandom_range(5);
    if (r == 5) return ChSpace;
    return ChTab + 8'(r);
  endfunction

  task automatic add_string(logic closed);
    logic [7:0] b;
    put_byte(ChQuote);
    repeat ($urandom_range(5)) begin
      do b = 8'($urandom_range(255)); while (b == ChQuote);
      put_byte(b);
    end
    if (closed) put_byte(ChQuote);
  endtask

  task automatic add_comment(logic closed);
    logic [7:0] b;
    put_byte(ChHash);
    repeat ($urandom_range(5)) begin
      do b = 8'($urandom_range(255)); while (b == ChNewline);
      put_byte(b);
    end
    if (closed) put_byte(ChNewline);
  endtask

  task automatic add_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 18) begin
      put_byte(rand_letter());
      repeat ($urandom_range(5)) begin
        if ($urandom_range(3) == 0) put_byte(rand_digit());
        else put_byte(rand_letter());
      end
    end else if (pick < 38) begin
      if ($urandom_range(2) == 0) put_byte(ChMinus);
      repeat ($urandom_range(1, 4)) put_byte(rand_digit());
      if ($urandom_range(1)) begin
        put_byte(ChDot);
        repeat ($urandom_range(3)) put_byte(rand_digit());
        if ($urandom_range(4) == 0) begin
          put_byte(ChDot);
          put_byte(rand_digit());
        end
      end
    end else if (pick < 52) begin
      add_string(1'b1);
    end else if (pick < 64) begin
      case ($urandom_range(3))
        0: put_byte(ChLess);
        1: put_byte(ChGreater);
        2: put_byte(ChBang);
        default: put_byte(ChEq);
      endcase
      if ($urandom_range(1)) put_byte(ChEq);
    end else if (pick < 70) begin
      put_byte(ChMinus);
    end else if (pick < 77) begin
      add_comment(1'b1);
    end else if (pick < 85) begin
      put_byte(ChComma);
    end else begin
      put_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic add_source();
    int           ntok;
    source_item_t last;
    ntok = $urandom_range(1, 6);
    for (int t = 0; t < ntok; t++) begin
      if (t == ntok - 1 && $urandom_range(7) == 0) begin
        if ($urandom_range(1)) add_string(1'b0);
        else add_comment(1'b0);
      end else begin
        add_token();
      end
      if ($urandom_range(1)) put_byte(rand_space());
    end
    last = sources[sources.size() - 1];
    last.fin = 1'b1;
    sources[sources.size() - 1] = last;
  endtask

  // receiver: random stall, plus one long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_taken <= 1'b1;
      hold_left  <= 200;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got = {kind_t'(token_kind), text_byte, token_first, token_last, token_empty,
             whole_number, run_end};
      if (token_queue.size() == 0) begin
        note_mismatch($sformatf("unexpected item kind %0d text %02h", token_kind, text_byte));
      end else begin
        want = token_queue.pop_front();
        if (got !== want) begin
          note_mismatch($sformatf(
            {"got kind %0d text %02h f%b l%b e%b w%b r%b, ",
             "want kind %0d text %02h f%b l%b e%b w%b r%b"},
            got.kind, got.text, got.first, got.last, got.empty, got.whole, got.run_end,
            want.kind, want.text, want.first, want.last, want.empty, want.whole,
            want.run_end));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int total;
    go_idle();

    row_typed(ChComma, 1'b0, 2'd1, tok(KIND_PUNCT, ChComma, 1, 1, 0, 0, 1));
    row_typed(8'h00, 1'b0, 2'd1, tok(KIND_PUNCT, 8'h00, 1, 1, 0, 0, 1));
    row_typed(8'hff, 1'b1, 2'd2, tok(KIND_PUNCT, 8'hff, 1, 1, 0, 0, 0),
              tok(KIND_END, 8'h00, 1, 1, 1, 0, 1));
    row_typed(ChQuote, 1'b0, 2'd0);
    row_typed(ChQuote, 1'b0, 2'd1, tok(KIND_STRING, 8'h00, 1, 1, 1, 0, 1));
    row_typed(ChQuote, 1'b0, 2'd0);
    row_typed(ChLowA, 1'b1, 2'd1, tok(KIND_ERROR, 8'h00, 1, 1, 1, 0, 1));
    row_typed(ChSpace, 1'b1, 2'd1, tok(KIND_END, 8'h00, 1, 1, 1, 0, 1));
    row(ChHash, 1'b0);
    row(ChQuote, 1'b0);
    row(ChNewline, 1'b0);
    row(ChMinus, 1'b0);
    row(ChZero + 8'd1, 1'b0);
    row(ChDot, 1'b0);
    row(ChZero + 8'd5, 1'b0);
    row(ChDot, 1'b0);
    row(ChUnder, 1'b0);
    row(ChNine, 1'b0);
    row(ChLess, 1'b0);
    row(ChEq, 1'b0);
    row(ChBang, 1'b0);
    row(ChLowA + 8'd23, 1'b0);
    row(ChMinus, 1'b0);
    row(ChTab, 1'b0);
    row(ChGreater, 1'b1);

    while (sources.size() < 175) add_source();
    total = sources.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    tx_idle = 15;
    rx_idle = 80;
    foreach (directed[i]) begin
      send(directed[i].src, directed[i].fin);
      scan_byte(directed[i].src, directed[i].fin);
      if (directed[i].typed) begin
        for (int j = 0; j < directed[i].n; j++) token_queue = {token_queue, directed[i].want[j]};
      end else begin
        foreach (step_out[j]) token_queue = {token_queue, step_out[j]};
      end
    end

    for (int i = 0; i < total; i++) begin
      if (i == total / 3) begin
        tx_idle = 80;
        rx_idle = 15;
      end else if (i == 2 * total / 3) begin
        tx_idle  = 0;
        rx_idle  = 0;
        hold_req = 1'b1;
      end
      send(sources[i].src, sources[i].fin);
      scan_byte(sources[i].src, sources[i].fin);
      foreach (step_out[j]) token_queue = {token_queue, step_out[j]};
    end
    in_valid <= 1'b0;

    while (token_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0 && token_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/qtt_pkg.sv
rtl/qtt_scan.sv
rtl/qtt_fifo.sv
rtl/query_text_tokenizer.sv
verif/query_text_tokenizer_test.sv
